// ===== hdl/mhs_pkg.sv =====
// shared types and constants for the motion half-step block copy
package mhs_pkg;

  localparam int IMG_W       = 13;  // image width / height register width
  localparam int BLK_W       = 7;   // block width / height register width
  localparam int IDX_W       = 12;  // block column / row index width
  localparam int MOT_W       = 12;  // motion component width
  localparam int RND_W       = 9;   // rounded motion width
  localparam int HALF_W      = 8;   // halved rounded motion width
  localparam int SRC_W       = 24;  // source offset width
  localparam int DEST_W      = 25;  // destination offset width
  localparam int OFS_W       = 25;  // running row offset width
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int MUL_A_W     = 20;
  localparam int MUL_B_W     = 14;
  localparam int PROD_W      = 34;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLOCK_WIDTH  = 2'd2,
    CFG_BLOCK_HEIGHT = 2'd3
  } cfg_idx_e;

  // clamped configuration seen by the datapath
  typedef struct packed {
    logic [IMG_W-1:0] image_width;
    logic [IMG_W-1:0] image_height;
    logic [BLK_W-1:0] block_width;
    logic [BLK_W-1:0] block_height;
  } cfg_t;

  // one kept block: first row offsets
  typedef struct packed {
    logic [OFS_W-1:0] src;
    logic [OFS_W-1:0] dest;
  } copy_cmd_t;

endpackage

// ===== hdl/mhs_if.sv =====
// stream interfaces for block vectors in and row copy commands out
interface mhs_in_if;
  logic                                valid;
  logic                                ready;
  logic        [mhs_pkg::IDX_W-1:0]    block_col;
  logic        [mhs_pkg::IDX_W-1:0]    block_row;
  logic signed [mhs_pkg::MOT_W-1:0]    motion_x;
  logic signed [mhs_pkg::MOT_W-1:0]    motion_y;

  modport source (output valid, block_col, block_row, motion_x, motion_y, input ready);
  modport sink   (input valid, block_col, block_row, motion_x, motion_y, output ready);
endinterface

interface mhs_out_if;
  logic                                valid;
  logic                                ready;
  logic        [mhs_pkg::SRC_W-1:0]    src_offset;
  logic signed [mhs_pkg::DEST_W-1:0]   dest_offset;
  logic        [mhs_pkg::BLK_W-1:0]    row_bytes;
  logic                                last_row;

  modport source (output valid, src_offset, dest_offset, row_bytes, last_row, input ready);
  modport sink   (input valid, src_offset, dest_offset, row_bytes, last_row, output ready);
endinterface

// ===== hdl/mhs_front.sv =====
// front end: rounds motion, forms offsets with one shared multiplier, applies bounds test
module mhs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhs_pkg::cfg_t       cfg_i,
  mhs_in_if.sink              blk_i,
  output logic                push_valid_o,
  output mhs_pkg::copy_cmd_t  push_cmd_o,
  input  logic                push_ready_i
);

  typedef enum logic [2:0] {
    F_IDLE   = 3'b001,
    F_CALC   = 3'b010,
    F_DECIDE = 3'b100
  } front_state_e;

  localparam logic [2:0] STEP_ROW_BH  = 3'd0;
  localparam logic [2:0] STEP_ORG_ROW = 3'd1;
  localparam logic [2:0] STEP_ORG_COL = 3'd2;
  localparam logic [2:0] STEP_FULL    = 3'd3;
  localparam logic [2:0] STEP_HALF    = 3'd4;
  localparam logic [2:0] STEP_SPAN    = 3'd5;
  localparam logic [2:0] STEP_FRAME   = 3'd6;

  front_state_e state_q, state_d;
  logic [2:0]   step_q, step_d;

  logic        [mhs_pkg::IDX_W-1:0]   col_q, row_q;
  logic signed [mhs_pkg::RND_W-1:0]   mx_q, my_q;
  logic signed [mhs_pkg::HALF_W-1:0]  hx_q, hy_q;
  logic                               small_q;
  logic        [mhs_pkg::MUL_A_W-1:0] rb_q;
  logic signed [mhs_pkg::PROD_W-1:0]  org_q, full_q, half_q, span_q, frame_q, src_q;

  logic signed [mhs_pkg::MOT_W:0]     mx_bias, my_bias;
  logic signed [mhs_pkg::RND_W-1:0]   mx_rnd, my_rnd, mx_adj, my_adj;
  logic signed [mhs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mhs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mhs_pkg::PROD_W-1:0]  prod;
  logic signed [mhs_pkg::PROD_W-1:0]  src_end;
  logic                               keep;
  logic                               accept;

  assign blk_i.ready = (state_q == F_IDLE);
  assign accept      = blk_i.valid && blk_i.ready;

  // floor(m/16 + 1/2): bias by half a pixel, keep the integer bits
  assign mx_bias = (mhs_pkg::MOT_W+1)'(blk_i.motion_x) + 13'sd8;
  assign my_bias = (mhs_pkg::MOT_W+1)'(blk_i.motion_y) + 13'sd8;
  assign mx_rnd  = mx_bias[mhs_pkg::MOT_W:4];
  assign my_rnd  = my_bias[mhs_pkg::MOT_W:4];
  // halving toward zero: add one to negatives before the shift
  assign mx_adj  = mx_rnd + {{(mhs_pkg::RND_W-1){1'b0}}, mx_rnd[mhs_pkg::RND_W-1]};
  assign my_adj  = my_rnd + {{(mhs_pkg::RND_W-1){1'b0}}, my_rnd[mhs_pkg::RND_W-1]};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      STEP_ROW_BH: begin
        mul_a = {8'b0, row_q};
        mul_b = {7'b0, cfg_i.block_height};
      end
      STEP_ORG_ROW: begin
        mul_a = rb_q;
        mul_b = {1'b0, cfg_i.image_width};
      end
      STEP_ORG_COL: begin
        mul_a = {8'b0, col_q};
        mul_b = {7'b0, cfg_i.block_width};
      end
      STEP_FULL: begin
        mul_a = mhs_pkg::MUL_A_W'(my_q);
        mul_b = {1'b0, cfg_i.image_width};
      end
      STEP_HALF: begin
        mul_a = mhs_pkg::MUL_A_W'(hy_q);
        mul_b = {1'b0, cfg_i.image_width};
      end
      STEP_SPAN: begin
        mul_a = {13'b0, cfg_i.block_height};
        mul_b = {1'b0, cfg_i.image_width};
      end
      STEP_FRAME: begin
        mul_a = {7'b0, cfg_i.image_width};
        mul_b = {1'b0, cfg_i.image_height};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign src_end = src_q + span_q;
  assign keep    = !small_q && !src_q[mhs_pkg::PROD_W-1] && (src_end < frame_q);

  assign push_valid_o    = (state_q == F_DECIDE) && keep;
  assign push_cmd_o.src  = src_q[mhs_pkg::OFS_W-1:0];
  assign push_cmd_o.dest = mhs_pkg::OFS_W'(org_q + half_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_CALC;
          step_d  = STEP_ROW_BH;
        end
      end
      F_CALC: begin
        step_d = step_q + 3'd1;
        if (step_q == STEP_FRAME) begin
          state_d = F_DECIDE;
        end
      end
      F_DECIDE: begin
        if (!keep || push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= STEP_ROW_BH;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q   <= blk_i.block_col;
      row_q   <= blk_i.block_row;
      mx_q    <= mx_rnd;
      my_q    <= my_rnd;
      hx_q    <= mx_adj[mhs_pkg::RND_W-1:1];
      hy_q    <= my_adj[mhs_pkg::RND_W-1:1];
      small_q <= (mx_rnd >= -9'sd1) && (mx_rnd <= 9'sd1) &&
                 (my_rnd >= -9'sd1) && (my_rnd <= 9'sd1);
    end
    if (state_q == F_CALC) begin
      case (step_q)
        STEP_ROW_BH:  rb_q    <= prod[mhs_pkg::MUL_A_W-1:0];
        STEP_ORG_ROW: org_q   <= prod;
        STEP_ORG_COL: org_q   <= org_q + prod;
        STEP_FULL:    full_q  <= prod + mhs_pkg::PROD_W'(mx_q);
        STEP_HALF:    half_q  <= prod + mhs_pkg::PROD_W'(hx_q);
        STEP_SPAN:    span_q  <= prod + $signed({27'b0, cfg_i.block_width});
        STEP_FRAME: begin
          frame_q <= prod;
          src_q   <= org_q + full_q;
        end
        default: ;
      endcase
    end
  end

  // a new item always starts at the first multiply step
  a_start_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == F_CALC) && (step_q == STEP_ROW_BH))
    else $error("front did not restart its step count");

endmodule

// ===== hdl/mhs_queue.sv =====
// short fifo of kept blocks between front and back
module mhs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  mhs_pkg::copy_cmd_t  push_cmd_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output mhs_pkg::copy_cmd_t  pop_cmd_o,
  input  logic                pop_ready_i
);

  localparam int PTR_W = (mhs_pkg::QUEUE_DEPTH > 1) ? $clog2(mhs_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mhs_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mhs_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(mhs_pkg::QUEUE_DEPTH);

  mhs_pkg::copy_cmd_t entry_q [mhs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue count past depth");

endmodule

// ===== hdl/mhs_back.sv =====
// back end: walks the rows of one kept block and registers each copy command
module mhs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhs_pkg::cfg_t       cfg_i,
  input  logic                pop_valid_i,
  input  mhs_pkg::copy_cmd_t  pop_cmd_i,
  output logic                pop_ready_o,
  mhs_out_if.source           cmd_o
);

  logic                        busy_q;
  logic [mhs_pkg::BLK_W-1:0]   rows_left_q;
  logic [mhs_pkg::OFS_W-1:0]   cur_src_q, cur_dest_q;
  logic                        out_valid_q;
  logic [mhs_pkg::SRC_W-1:0]   out_src_q;
  logic [mhs_pkg::DEST_W-1:0]  out_dest_q;
  logic [mhs_pkg::BLK_W-1:0]   out_bytes_q;
  logic                        out_last_q;
  logic                        slot_free, issue, load, last;

  assign pop_ready_o = !busy_q;
  assign load        = pop_valid_i && !busy_q;
  assign slot_free   = !out_valid_q || cmd_o.ready;
  assign issue       = busy_q && slot_free;
  assign last        = (rows_left_q == mhs_pkg::BLK_W'(1));

  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.src_offset  = out_src_q;
  assign cmd_o.dest_offset = out_dest_q;
  assign cmd_o.row_bytes   = out_bytes_q;
  assign cmd_o.last_row    = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rows_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        // zero block height: nothing to emit
        busy_q      <= (cfg_i.block_height != '0);
        rows_left_q <= cfg_i.block_height;
      end else if (issue) begin
        busy_q      <= !last;
        rows_left_q <= rows_left_q - mhs_pkg::BLK_W'(1);
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (cmd_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_src_q  <= pop_cmd_i.src;
      cur_dest_q <= pop_cmd_i.dest;
    end else if (issue) begin
      cur_src_q  <= cur_src_q + mhs_pkg::OFS_W'(cfg_i.image_width);
      cur_dest_q <= cur_dest_q + mhs_pkg::OFS_W'(cfg_i.image_width);
    end
    if (issue) begin
      out_src_q   <= cur_src_q[mhs_pkg::SRC_W-1:0];
      out_dest_q  <= cur_dest_q;
      out_bytes_q <= cfg_i.block_width;
      out_last_q  <= last;
    end
  end

  a_busy_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rows_left_q != '0))
    else $error("row walker busy with no rows left");

  // the next block must be loaded first, so no row issues right after a block's last row
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && last) |=> !issue)
    else $error("row issued right after a block's last row");

endmodule

// ===== hdl/motion_half_step_block_copy.sv =====
// top level: configuration registers, front end, queue and row walker
//
// Each transaction on blk_i carries one block's column, row and motion vector
// (signed, four fraction bits). Both components are rounded to the nearest
// pixel; a block that moves at most one pixel in both axes, or whose source
// falls outside the frame, yields nothing. A kept block yields block_height
// row copy transactions on cmd_o, each with source and destination offsets,
// the row length and a flag on the last row. The front end accepts a block,
// forms seven products through a single shared 20x14 multiplier and then
// applies the bounds test; it takes no new block until that one is decided.
// The row walker loads a kept block and then issues one row per cycle while
// cmd_o is ready; a two-entry queue lets both run at once. Register writes
// on the config port take effect at once and are meant to be made while no
// block is in flight; oversized sizes are clamped to the maximum image and
// block sides.
module motion_half_step_block_copy #(
  parameter int MAX_BLOCK_SIDE = 64,
  parameter int MAX_IMAGE_SIDE = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mhs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mhs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  mhs_in_if.sink                             blk_i,
  mhs_out_if.source                          cmd_o
);

  localparam logic [mhs_pkg::IMG_W-1:0] IMG_MAX = mhs_pkg::IMG_W'(MAX_IMAGE_SIDE);
  localparam logic [mhs_pkg::BLK_W-1:0] BLK_MAX = mhs_pkg::BLK_W'(MAX_BLOCK_SIDE);

  // raw register values, reset to a 640x480 frame with 8x8 blocks
  logic [mhs_pkg::IMG_W-1:0] image_width_q, image_height_q;
  logic [mhs_pkg::BLK_W-1:0] block_width_q, block_height_q;
  mhs_pkg::cfg_t             cfg;

  // front to queue and queue to back
  logic                      push_valid, push_ready;
  mhs_pkg::copy_cmd_t        push_cmd;
  logic                      pop_valid, pop_ready;
  mhs_pkg::copy_cmd_t        pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 13'd640;
      image_height_q <= 13'd480;
      block_width_q  <= 7'd8;
      block_height_q <= 7'd8;
    end else if (cfg_we_i) begin
      case (mhs_pkg::cfg_idx_e'(cfg_idx_i))
        mhs_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
        mhs_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        mhs_pkg::CFG_BLOCK_WIDTH:  block_width_q  <= cfg_data_i[mhs_pkg::BLK_W-1:0];
        mhs_pkg::CFG_BLOCK_HEIGHT: block_height_q <= cfg_data_i[mhs_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes to the supported maximum
  assign cfg.image_width  = (image_width_q  > IMG_MAX) ? IMG_MAX : image_width_q;
  assign cfg.image_height = (image_height_q > IMG_MAX) ? IMG_MAX : image_height_q;
  assign cfg.block_width  = (block_width_q  > BLK_MAX) ? BLK_MAX : block_width_q;
  assign cfg.block_height = (block_height_q > BLK_MAX) ? BLK_MAX : block_height_q;

  // rounding, offsets and bounds test
  mhs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .blk_i        (blk_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  // decouples the multiply sequence from row issue
  mhs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // one row command per cycle into the output register while cmd_o is ready
  mhs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .cmd_o       (cmd_o)
  );

endmodule

// ===== bench/motion_half_step_block_copy_tb.sv =====
// testbench for the motion half-step block copy: directed and random block vectors
`timescale 1ns / 100ps

module motion_half_step_block_copy_tb;

  localparam int  MAX_BLOCK   = 64;
  localparam int  MAX_IMAGE   = 4096;
  localparam int  SETTLE      = 20;         // lets the front end finish its last block, plus margin
  localparam int  TAIL        = 80;         // walker load plus a full 64-row block
  localparam int  IDLE_PCT    = 36;
  localparam int  MAX_REPORTS = 10;

  // one block vector as offered on blk_i
  typedef struct packed {
    logic        [mhs_pkg::IDX_W-1:0] col;
    logic        [mhs_pkg::IDX_W-1:0] row;
    logic signed [mhs_pkg::MOT_W-1:0] mx;
    logic signed [mhs_pkg::MOT_W-1:0] my;
  } blk_vec_t;

  // one row copy command as seen on cmd_o
  typedef struct packed {
    logic [mhs_pkg::SRC_W-1:0]  src;
    logic [mhs_pkg::DEST_W-1:0] dest;
    logic [mhs_pkg::BLK_W-1:0]  nbytes;
    logic                       last;
  } row_cmd_t;

  typedef struct {
    int iw;
    int ih;
    int bw;
    int bh;
    int items;
  } frame_plan_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [mhs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mhs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  mhs_in_if  blk ();
  mhs_out_if cmd ();

  motion_half_step_block_copy i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .blk_i      (blk),
    .cmd_o      (cmd)
  );

  // shadow copy of the config registers, as written (masked, not clamped)
  logic [mhs_pkg::IMG_W-1:0] img_w_reg = 13'd640;
  logic [mhs_pkg::IMG_W-1:0] img_h_reg = 13'd480;
  logic [mhs_pkg::BLK_W-1:0] blk_w_reg = 7'd8;
  logic [mhs_pkg::BLK_W-1:0] blk_h_reg = 7'd8;

  row_cmd_t rows_due[$];     // row commands predicted and not yet seen
  bit       steady;          // when set neither side idles
  int       mismatches;
  int       blocks_sent;
  int       blocks_kept;
  int       rows_checked;
  int       settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver side: ready toggles at random except during the steady stretch
  always @(negedge clk_i) begin
    cmd.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic longint clamp_side(longint v, longint top);
    return v > top ? top : v;
  endfunction

  // works out the row commands one block vector produces and queues them
  function automatic int plan_row_copies(blk_vec_t v);
    longint                    w, h, bw, bh, mx, my, full, half, origin, src;
    logic [mhs_pkg::OFS_W-1:0] run_src, run_dest;
    row_cmd_t                  rc;
    w  = clamp_side(img_w_reg, MAX_IMAGE);
    h  = clamp_side(img_h_reg, MAX_IMAGE);
    bw = clamp_side(blk_w_reg, MAX_BLOCK);
    bh = clamp_side(blk_h_reg, MAX_BLOCK);
    // round to nearest pixel: floor(m/16 + 1/2)
    mx = (longint'($signed(v.mx)) + 8) >>> 4;
    my = (longint'($signed(v.my)) + 8) >>> 4;
    if (mx >= -1 && mx <= 1 && my >= -1 && my <= 1) return 0;
    full   = mx + my * w;
    half   = mx / 2 + (my / 2) * w;   // halving truncates toward zero
    origin = longint'(v.row) * bh * w + longint'(v.col) * bw;
    src    = origin + full;
    if (src < 0 || src + bw + bh * w >= w * h) return 0;
    run_src  = mhs_pkg::OFS_W'(src);
    run_dest = mhs_pkg::OFS_W'(origin + half);
    for (longint r = 0; r < bh; r++) begin
      rc.src    = run_src[mhs_pkg::SRC_W-1:0];
      rc.dest   = run_dest;
      rc.nbytes = mhs_pkg::BLK_W'(bw);
      rc.last   = (r == bh - 1);
      rows_due.push_back(rc);
      run_src  = run_src + mhs_pkg::OFS_W'(w);
      run_dest = run_dest + mhs_pkg::OFS_W'(w);
    end
    return int'(bh);
  endfunction

  // compare each row command against the oldest prediction
  always @(posedge clk_i) begin : check_rows
    row_cmd_t got, due;
    if (rst_ni && cmd.valid && cmd.ready) begin
      got = '{cmd.src_offset, cmd.dest_offset, cmd.row_bytes, cmd.last_row};
      if (rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected row command src=%0d dest=%0d bytes=%0d last=%0b",
                   $realtime, got.src, $signed(got.dest), got.nbytes, got.last);
      end else begin
        due = rows_due.pop_front();
        rows_checked++;
        if (got !== due) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: row mismatch exp src=%0d dest=%0d bytes=%0d last=%0b, ",
                      "got src=%0d dest=%0d bytes=%0d last=%0b"},
                     $realtime, due.src, $signed(due.dest), due.nbytes, due.last,
                     got.src, $signed(got.dest), got.nbytes, got.last);
        end
      end
    end
  end

  // offer one block vector, predict its rows on acceptance; valid stays high
  task automatic send_block(input blk_vec_t v);
    int n;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      blk.valid <= 1'b0;
      @(negedge clk_i);
    end
    blk.valid     <= 1'b1;
    blk.block_col <= v.col;
    blk.block_row <= v.row;
    blk.motion_x  <= v.mx;
    blk.motion_y  <= v.my;
    @(posedge clk_i);
    while (!blk.ready) @(posedge clk_i);
    n = plan_row_copies(v);
    blocks_sent++;
    if (n > 0) blocks_kept++;
    @(negedge clk_i);
  endtask

  // sender holds off until every predicted row has come back
  task automatic drain_rows();
    blk.valid <= 1'b0;
    @(negedge clk_i);
    while (rows_due.size() != 0) @(negedge clk_i);
  endtask

  // one register write transaction; write enable is left high for the caller to clear
  task automatic write_reg(input mhs_pkg::cfg_idx_e idx,
                           input logic [mhs_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    case (idx)
      mhs_pkg::CFG_IMAGE_WIDTH:  img_w_reg = data;
      mhs_pkg::CFG_IMAGE_HEIGHT: img_h_reg = data;
      mhs_pkg::CFG_BLOCK_WIDTH:  blk_w_reg = data[mhs_pkg::BLK_W-1:0];
      mhs_pkg::CFG_BLOCK_HEIGHT: blk_h_reg = data[mhs_pkg::BLK_W-1:0];
      default: ;
    endcase
  endtask

  // reprogram all four sizes once the block has gone quiet
  task automatic set_frame(input logic [mhs_pkg::CFG_DATA_W-1:0] iw, ih, bw, bh);
    drain_rows();
    repeat (SETTLE) @(negedge clk_i);
    write_reg(mhs_pkg::CFG_IMAGE_WIDTH, iw);
    write_reg(mhs_pkg::CFG_IMAGE_HEIGHT, ih);
    write_reg(mhs_pkg::CFG_BLOCK_WIDTH, bw);
    write_reg(mhs_pkg::CFG_BLOCK_HEIGHT, bh);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  // mostly in-frame blocks with motion up to one of three limits, the rest raw noise
  function automatic blk_vec_t rand_block();
    blk_vec_t    v;
    logic [63:0] raw;
    longint      w, h, bw, bh, ncol, nrow;
    int          lim, m;
    w   = clamp_side(img_w_reg, MAX_IMAGE);
    h   = clamp_side(img_h_reg, MAX_IMAGE);
    bw  = clamp_side(blk_w_reg, MAX_BLOCK);
    bh  = clamp_side(blk_h_reg, MAX_BLOCK);
    raw = {$urandom(), $urandom()};
    v   = raw[$bits(blk_vec_t)-1:0];
    if ($urandom_range(99) < 80) begin
      ncol = (bw == 0) ? 64 : clamp_side(w / bw, 4096);
      nrow = (bh == 0) ? 64 : clamp_side(h / bh, 4096);
      if (ncol < 1) ncol = 1;
      if (nrow < 1) nrow = 1;
      v.col = mhs_pkg::IDX_W'($urandom_range(int'(ncol) - 1));
      v.row = mhs_pkg::IDX_W'($urandom_range(int'(nrow) - 1));
      case ($urandom_range(2))
        0:       lim = 48;
        1:       lim = 256;
        default: lim = 2047;
      endcase
      m    = int'($urandom_range(2 * lim)) - lim;
      v.mx = mhs_pkg::MOT_W'(m);
      m    = int'($urandom_range(2 * lim)) - lim;
      v.my = mhs_pkg::MOT_W'(m);
    end
    return v;
  endfunction

  // rounding thresholds, bounds test at top and bottom of the frame, negative destination,
  // field extremes, all at the reset sizes 640x480 with 8x8 blocks
  task automatic test_defaults();
    send_block('{12'd0,    12'd0,    12'sd0,     12'sd0});     // no move
    send_block('{12'd0,    12'd0,    12'sd23,    -12'sd24});   // rounds to 1 / -1
    send_block('{12'd0,    12'd0,    12'sd24,    12'sd0});     // rounds to 2
    send_block('{12'd1,    12'd1,    -12'sd25,   12'sd7});     // rounds to -2
    send_block('{12'd0,    12'd0,    -12'sd2048, 12'sd16});    // dest below zero
    send_block('{12'd0,    12'd0,    12'sd0,     -12'sd32});   // source above frame
    send_block('{12'd79,   12'd59,   12'sd32,    12'sd0});     // past bottom edge
    send_block('{12'd78,   12'd58,   12'sd16,    12'sd32});
    send_block('{12'd0,    12'd0,    12'sd2047,  12'sd2047});  // largest move
    send_block('{12'd10,   12'd10,   -12'sd2048, -12'sd2048}); // large move out
    send_block('{12'd40,   12'd30,   -12'sd2048, -12'sd2048}); // large move kept
    send_block('{12'd4095, 12'd4095, 12'sd2047,  12'sd2047});  // index extremes
    send_block('{12'hAAA,  12'h555,  12'sh555,   12'shAAA});
  endtask

  // oversized registers clamp to 4096x4096 frames and 64x64 blocks
  task automatic test_clamped_sizes();
    set_frame(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'd100);
    send_block('{12'd0,  12'd0,  12'sd2047,  12'sd2047});
    send_block('{12'd63, 12'd63, -12'sd2048, -12'sd2048});
    send_block('{12'd63, 12'd63, 12'sd32,    12'sd32});   // just past the end
    send_block('{12'd5,  12'd7,  -12'sd100,  12'sd300});
  endtask

  // zero image sides, zero block sides and the smallest frames
  task automatic test_degenerate_sizes();
    set_frame(13'd0, 13'd480, 13'd8, 13'd8);
    send_block('{12'd0, 12'd0, 12'sd2047, 12'sd2047});
    set_frame(13'd640, 13'd0, 13'd8, 13'd8);
    send_block('{12'd1, 12'd1, 12'sd32, 12'sd32});
    set_frame(13'd640, 13'd480, 13'd8, 13'd0);        // kept but no rows
    send_block('{12'd1, 12'd1, 12'sd32, 12'sd32});
    set_frame(13'd640, 13'd480, 13'd0, 13'd8);        // rows of zero length
    send_block('{12'd1, 12'd1, 12'sd32, 12'sd32});
    set_frame(13'd1, 13'd1, 13'd1, 13'd1);
    send_block('{12'd0, 12'd0, 12'sd32, 12'sd0});
    set_frame(13'd16, 13'd16, 13'd1, 13'd1);
    send_block('{12'd3, 12'd3, 12'sd32, -12'sd32});
    send_block('{12'd15, 12'd15, -12'sd64, -12'sd64});
  endtask

  // random phases over a spread of frame and block sizes
  task automatic test_random_phases();
    frame_plan_t plan[7] = '{
      '{640,  480,  8,  8,  70},
      '{64,   48,   4,  4,  60},   // run without any idling
      '{4096, 4096, 16, 2,  50},
      '{100,  60,   3,  5,  60},
      '{33,   17,   1,  1,  60},
      '{256,  256,  64, 64, 20},
      '{1000, 700,  7,  13, 60}
    };
    foreach (plan[p]) begin
      set_frame(mhs_pkg::CFG_DATA_W'(plan[p].iw), mhs_pkg::CFG_DATA_W'(plan[p].ih),
                mhs_pkg::CFG_DATA_W'(plan[p].bw), mhs_pkg::CFG_DATA_W'(plan[p].bh));
      steady = (p == 1);
      for (int i = 0; i < plan[p].items; i++) begin
        // halfway through, let the output side catch up completely
        if (i == plan[p].items / 2) drain_rows();
        send_block(rand_block());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = mhs_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i    = '0;
    blk.valid     = 1'b0;
    blk.block_col = '0;
    blk.block_row = '0;
    blk.motion_x  = '0;
    blk.motion_y  = '0;
    steady        = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    settings_used = 1;

    test_defaults();
    test_clamped_sizes();
    test_degenerate_sizes();
    test_random_phases();

    // wait for the last rows, then watch a while for stray transactions
    drain_rows();
    repeat (TAIL) @(negedge clk_i);

    $display("%0d block vectors over %0d size settings, %0d kept blocks",
             blocks_sent, settings_used, blocks_kept);
    $display("%0d row commands checked, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0 && rows_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
